// ===== hdl/psgm_pkg.sv =====
// Shared types and constants for the packet sequence gap monitor.
package psgm_pkg;

  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TYPE_W  = 8;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SPAN_W  = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_FIRST  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_SECOND = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SPAN = 8'd3;

  // Reset values of the configuration registers
  localparam logic [LEN_W-1:0]  MIN_LENGTH_RST  = 16'd1044;
  localparam logic [TYPE_W-1:0] TYPE_FIRST_RST  = 8'h01;
  localparam logic [TYPE_W-1:0] TYPE_SECOND_RST = 8'h04;
  localparam logic [SPAN_W-1:0] WINDOW_SPAN_RST = 16'd1500;

  // One packet summary; last field in the lowest bits
  typedef struct packed {
    logic [SEQ_W-1:0]  seq_index;
    logic [TYPE_W-1:0] type_byte_b;
    logic [TYPE_W-1:0] type_byte_a;
    logic [LEN_W-1:0]  cap_length;
  } item_t;

  // One window report; last field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0] bad_type_total;
    logic [CNT_W-1:0] short_total;
    logic [CNT_W-1:0] missing_total;
    logic [CNT_W-1:0] good_total;
  } report_t;

  // Packet class, exactly one bit set for a valid item
  typedef struct packed {
    logic is_short;
    logic is_bad;
    logic is_good;
  } class_t;

  typedef struct packed {
    logic [LEN_W-1:0]  min_length;
    logic [TYPE_W-1:0] type_first;
    logic [TYPE_W-1:0] type_second;
    logic [SPAN_W-1:0] window_span;
  } cfg_t;

endpackage

// ===== hdl/psgm_classify.sv =====
// Packet classifier: short, wrong type or good.
module psgm_classify (
  input  psgm_pkg::item_t  item,
  input  psgm_pkg::cfg_t   cfg,
  output psgm_pkg::class_t cls
);

  logic short_pkt;
  logic type_ok;

  assign short_pkt = item.cap_length < cfg.min_length;
  assign type_ok   = (item.type_byte_a == cfg.type_first) &&
                     (item.type_byte_b == cfg.type_second);

  // Length check wins over the type check
  assign cls.is_short = short_pkt;
  assign cls.is_bad   = !short_pkt && !type_ok;
  assign cls.is_good  = !short_pkt && type_ok;

endmodule

// ===== hdl/psgm_stats.sv =====
// Sequence tracking, window counters and report generation.
module psgm_stats (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  psgm_pkg::class_t               cls,
  input  logic [psgm_pkg::SEQ_W-1:0]     seq,
  input  logic [psgm_pkg::SPAN_W-1:0]    window_span,
  output logic                           emit,
  output psgm_pkg::report_t              report
);

  logic [psgm_pkg::SEQ_W-1:0] last_seq, last_seq_next;
  logic [psgm_pkg::SEQ_W-1:0] window_end, window_end_next;
  logic [psgm_pkg::CNT_W-1:0] good_count, good_count_next;
  logic [psgm_pkg::CNT_W-1:0] missing_count, missing_count_next;
  logic [psgm_pkg::CNT_W-1:0] short_count, short_count_next;
  logic [psgm_pkg::CNT_W-1:0] bad_type_count, bad_type_count_next;

  logic [psgm_pkg::SEQ_W-1:0] expect_seq;
  logic [psgm_pkg::CNT_W-1:0] gap;
  logic [psgm_pkg::CNT_W-1:0] good_inc;
  logic                       reached;
  logic                       win_open;

  assign expect_seq = last_seq + 32'd1;
  assign gap        = seq - last_seq - 32'd1;
  assign good_inc   = good_count + 32'd1;
  assign reached    = seq >= window_end;
  assign win_open   = window_end != '0;

  always_comb begin
    last_seq_next       = last_seq;
    window_end_next     = window_end;
    good_count_next     = good_count;
    missing_count_next  = missing_count;
    short_count_next    = short_count;
    bad_type_count_next = bad_type_count;
    emit                = 1'b0;
    report.good_total     = good_inc;
    report.missing_total  = missing_count + ((seq > expect_seq) ? gap : '0);
    report.short_total    = short_count;
    report.bad_type_total = bad_type_count;
    if (step) begin
      if (cls.is_short) begin
        short_count_next = short_count + 32'd1;
      end else if (cls.is_bad) begin
        bad_type_count_next = bad_type_count + 32'd1;
      end else begin
        last_seq_next = seq;
        if (reached) begin
          window_end_next = seq + {{(psgm_pkg::SEQ_W-psgm_pkg::SPAN_W){1'b0}}, window_span};
          if (win_open) begin
            // Close the window: report and clear all counts
            emit                = 1'b1;
            good_count_next     = '0;
            missing_count_next  = '0;
            short_count_next    = '0;
            bad_type_count_next = '0;
          end else begin
            good_count_next = good_inc;
          end
        end else begin
          good_count_next = good_inc;
          if (seq != expect_seq) begin
            missing_count_next = missing_count + gap;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq       <= '0;
      window_end     <= '0;
      good_count     <= '0;
      missing_count  <= '0;
      short_count    <= '0;
      bad_type_count <= '0;
    end else begin
      last_seq       <= last_seq_next;
      window_end     <= window_end_next;
      good_count     <= good_count_next;
      missing_count  <= missing_count_next;
      short_count    <= short_count_next;
      bad_type_count <= bad_type_count_next;
    end
  end

endmodule

// ===== hdl/packet_sequence_gap_monitor.sv =====
// Top level of the packet sequence gap monitor: ports, registers and stage control.
// The monitor takes one packet summary request per cycle on the s_ side and
// classifies it as short (captured length below min_length), wrong type
// (type bytes differ from type_first/type_second) or good. Good packets are
// checked for gaps in their 32-bit sequence number; gaps add to a missing count
// that wraps modulo 2^32, so a backward or repeated number adds a large value.
// The first good packet opens a window ending window_span sequence numbers
// later; the good packet that reaches the window end closes it, and the monitor
// then sends one report request on the m_ side with the four counts and clears
// them. Throughput is one packet per cycle while the result register is free
// or being drained. The report is registered: the packet that closes the
// window sits in the input register while the single update stage feeds the
// result register. The s_ side keeps taking packets while a report waits, as
// long as the stage can drain; it stalls only when a held report blocks a
// pending packet. Configuration writes are always taken (cfg_ready is tied
// high) and must happen while the monitor is idle; writes to unknown indexes
// are dropped.
module packet_sequence_gap_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] cap_length, [23:16] type_byte_a, [31:24] type_byte_b, [63:32] seq_index
  input  logic [63:0]                         s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] good_total, [63:32] missing_total, [95:64] short_total,
  // [127:96] bad_type_total
  output logic [127:0]                        m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psgm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  psgm_pkg::cfg_t    cfg;
  psgm_pkg::item_t   item;
  logic              item_valid;
  psgm_pkg::class_t  cls;
  psgm_pkg::report_t report;
  psgm_pkg::report_t out_report;
  logic              emit;
  logic              advance;
  logic              step;

  // Configuration registers; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_length  <= psgm_pkg::MIN_LENGTH_RST;
      cfg.type_first  <= psgm_pkg::TYPE_FIRST_RST;
      cfg.type_second <= psgm_pkg::TYPE_SECOND_RST;
      cfg.window_span <= psgm_pkg::WINDOW_SPAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psgm_pkg::REG_MIN_LENGTH:  cfg.min_length  <= cfg_data;
        psgm_pkg::REG_TYPE_FIRST:  cfg.type_first  <= cfg_data[psgm_pkg::TYPE_W-1:0];
        psgm_pkg::REG_TYPE_SECOND: cfg.type_second <= cfg_data[psgm_pkg::TYPE_W-1:0];
        psgm_pkg::REG_WINDOW_SPAN: cfg.window_span <= cfg_data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // The stage advances when the result register is free or being drained
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !item_valid || advance;
  assign step     = item_valid && advance;

  // Input register: hold the packet until the stage consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= psgm_pkg::item_t'(s_tdata);
    end
  end

  psgm_classify u_classify (
    .item (item),
    .cfg  (cfg),
    .cls  (cls)
  );

  psgm_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cls         (cls),
    .seq         (item.seq_index),
    .window_span (cfg.window_span),
    .emit        (emit),
    .report      (report)
  );

  // Result register: load a report when the window closes, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_report <= report;
    end
  end

  assign m_tdata = out_report;

`ifndef SYNTH
  a_emit_only_good: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |-> cls.is_good)
    else $error("report emitted for a packet that is not good");

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register is empty");

  a_report_loaded: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> (m_tvalid && m_tdata == $past(report)))
    else $error("closed window report not presented");
`endif

endmodule
